@@ hw/rtl/uartrb_pkg.sv @@
// shared types and constants of the uart ring buffer event controller
`timescale 1ns / 1ps

package uartrb_pkg;

    // byte width of both rings
    localparam int BYTE_W = 8;

    // field widths of the stream items
    localparam int ACTION_W   = 3;
    localparam int EVENT_W    = 3;
    localparam int LEVEL_W    = 8;
    localparam int SPACE_W    = 9;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    // action carried in the input tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_RX_BYTE = 3'd0,
        ACT_READ    = 3'd1,
        ACT_WRITE   = 3'd2,
        ACT_TX_DONE = 3'd3,
        ACT_TICK    = 3'd4
    } t_action;

    // status event codes
    localparam logic [EVENT_W-1:0] EV_IDLE       = 3'd0;
    localparam logic [EVENT_W-1:0] EV_RX_FULL    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_RX_HALF    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RX_TIMEOUT = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TX_IDLE    = 3'd4;

    // reset value of the receive timeout register
    localparam logic [LEVEL_W-1:0] TIMEOUT_RESET = 8'd6;

endpackage

@@ hw/rtl/uartrb_ram.sv @@
// byte-wide ring storage with one write port and one registered read port
`timescale 1ns / 1ps

module uartrb_ram
    import uartrb_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/uart_ring_buffer_event_controller.sv @@
// top level: receive and transmit rings with status event reporting
`timescale 1ns / 1ps

// UART buffering controller. Each input item carries an action in tuser
// (rx_byte, read, write, tx_done, tick) and a byte in tdata; each item gives
// exactly one result item. An item is accepted in ST_IDLE; in ST_MEM, once the
// output register is free, its result is loaded into the output register.
// No new item is taken before that, since the ring memories have a registered
// read port (a read or a transmit launch fetches its byte from memory before
// the result can be formed). The input is taken again while the previous
// result still waits in the output register.
// Both rings keep one slot unused, so they hold RX_DEPTH-1 and TX_DEPTH-1
// bytes; a receive byte arriving at a full ring is dropped with accepted 0.
// The rings need no clearing after reset: the block is ready at once.

module uart_ring_buffer_event_controller
    import uartrb_pkg::*;
#(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: receive timeout in ticks
    input  logic                  i_cfg_we,
    input  logic [LEVEL_W-1:0]    i_cfg_wdata,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] data_in
    input  logic [ACTION_W-1:0]   s_axis_tuser,  // [2:0] action
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] accepted, [8:1] read_data, [9] send_valid, [17:10] send_data,
    // [20:18] event_code, [28:21] rx_level, [37:29] tx_space, [39:38] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [RX_AW-1:0] RX_HALF = RX_AW'(RX_DEPTH / 2);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_MEM
    } t_state;

    t_state r_state;

    // ring control state
    logic [RX_AW-1:0]   r_rx_rd, n_rx_rd;
    logic [RX_AW-1:0]   r_rx_wr, n_rx_wr;
    logic [RX_AW-1:0]   r_rx_count, n_rx_count;
    logic [TX_AW-1:0]   r_tx_rd, n_tx_rd;
    logic [TX_AW-1:0]   r_tx_wr, n_tx_wr;
    logic [TX_AW-1:0]   r_tx_count, n_tx_count;
    logic               r_tx_busy, n_tx_busy;
    logic [LEVEL_W-1:0] r_countdown, n_countdown;
    logic [LEVEL_W-1:0] r_timeout;

    // result fields held while the memory read completes
    logic               r_p_acc, n_p_acc;
    logic               r_p_read, n_p_read;
    logic               r_p_send, n_p_send;
    logic               r_p_fwd, n_p_fwd;
    logic [BYTE_W-1:0]  r_p_fwd_data;
    logic [EVENT_W-1:0] r_p_event, n_p_event;
    logic [LEVEL_W-1:0] r_p_level;
    logic [SPACE_W-1:0] r_p_space;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // memory ports
    logic               rx_we, rx_re, tx_we, tx_re;
    logic [BYTE_W-1:0]  rx_rdata, tx_rdata;
    logic [TX_AW-1:0]   tx_cnt_w;

    logic               s_fire;
    logic               out_free;
    logic [BYTE_W-1:0]  rd_byte, sd_byte;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    uartrb_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (s_axis_tdata),
        .i_re    (rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    uartrb_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (s_axis_tdata),
        .i_re    (tx_re),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_rdata)
    );

    // action decode and next ring state
    always_comb begin
        n_rx_rd     = r_rx_rd;
        n_rx_wr     = r_rx_wr;
        n_rx_count  = r_rx_count;
        n_tx_rd     = r_tx_rd;
        n_tx_wr     = r_tx_wr;
        n_tx_count  = r_tx_count;
        n_tx_busy   = r_tx_busy;
        n_countdown = r_countdown;
        n_p_acc     = 1'b0;
        n_p_read    = 1'b0;
        n_p_send    = 1'b0;
        n_p_fwd     = 1'b0;
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        tx_cnt_w    = r_tx_count;
        if (s_fire) begin
            unique case (t_action'(s_axis_tuser))
                ACT_RX_BYTE: begin
                    if (r_rx_count != RX_LAST) begin
                        rx_we      = 1'b1;
                        n_rx_wr    = (r_rx_wr == RX_LAST) ? '0 : r_rx_wr + 1'b1;
                        n_rx_count = r_rx_count + 1'b1;
                        n_p_acc    = 1'b1;
                    end
                    n_countdown = r_timeout;
                end
                ACT_READ: begin
                    if (r_rx_count != '0) begin
                        rx_re      = 1'b1;
                        n_rx_rd    = (r_rx_rd == RX_LAST) ? '0 : r_rx_rd + 1'b1;
                        n_rx_count = r_rx_count - 1'b1;
                        n_p_acc    = 1'b1;
                        n_p_read   = 1'b1;
                    end
                end
                ACT_WRITE: begin
                    if (r_tx_count != TX_LAST) begin
                        tx_we    = 1'b1;
                        n_tx_wr  = (r_tx_wr == TX_LAST) ? '0 : r_tx_wr + 1'b1;
                        tx_cnt_w = r_tx_count + 1'b1;
                        n_p_acc  = 1'b1;
                    end
                    n_tx_count = tx_cnt_w;
                    // launch at once when the transmitter is idle
                    if (!r_tx_busy && tx_cnt_w != '0) begin
                        n_tx_busy  = 1'b1;
                        n_p_send   = 1'b1;
                        // an empty ring pops the byte just written
                        n_p_fwd    = (r_tx_count == '0);
                        tx_re      = (r_tx_count != '0);
                        n_tx_rd    = (r_tx_rd == TX_LAST) ? '0 : r_tx_rd + 1'b1;
                        n_tx_count = tx_cnt_w - 1'b1;
                    end
                end
                ACT_TX_DONE: begin
                    if (r_tx_busy) begin
                        if (r_tx_count == '0) begin
                            n_tx_busy = 1'b0;
                        end else begin
                            tx_re      = 1'b1;
                            n_p_send   = 1'b1;
                            n_tx_rd    = (r_tx_rd == TX_LAST) ? '0 : r_tx_rd + 1'b1;
                            n_tx_count = r_tx_count - 1'b1;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_countdown != '0) begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // status event from the state after the action
    always_comb begin
        priority if (n_rx_count >= RX_LAST) begin
            n_p_event = EV_RX_FULL;
        end else if (n_rx_count >= RX_HALF) begin
            n_p_event = EV_RX_HALF;
        end else if (n_rx_count != '0 && n_countdown == '0) begin
            n_p_event = EV_RX_TIMEOUT;
        end else if (!n_tx_busy) begin
            n_p_event = EV_TX_IDLE;
        end else begin
            n_p_event = EV_IDLE;
        end
    end

    // bytes fetched from memory or forwarded
    assign rd_byte = r_p_read ? rx_rdata : '0;
    assign sd_byte = r_p_send ? (r_p_fwd ? r_p_fwd_data : tx_rdata) : '0;

    // sequencer, ring state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_rd     <= '0;
            r_rx_wr     <= '0;
            r_rx_count  <= '0;
            r_tx_rd     <= '0;
            r_tx_wr     <= '0;
            r_tx_count  <= '0;
            r_tx_busy   <= 1'b0;
            r_countdown <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            // output valid: set when a result is formed, cleared when taken
            if (r_state == ST_MEM && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_fire) begin
                        r_rx_rd      <= n_rx_rd;
                        r_rx_wr      <= n_rx_wr;
                        r_rx_count   <= n_rx_count;
                        r_tx_rd      <= n_tx_rd;
                        r_tx_wr      <= n_tx_wr;
                        r_tx_count   <= n_tx_count;
                        r_tx_busy    <= n_tx_busy;
                        r_countdown  <= n_countdown;
                        r_p_acc      <= n_p_acc;
                        r_p_read     <= n_p_read;
                        r_p_send     <= n_p_send;
                        r_p_fwd      <= n_p_fwd;
                        r_p_fwd_data <= s_axis_tdata;
                        r_p_event    <= n_p_event;
                        r_p_level    <= LEVEL_W'(n_rx_count);
                        r_p_space    <= SPACE_W'(TX_LAST - n_tx_count);
                        r_state      <= ST_MEM;
                    end
                end
                ST_MEM: begin
                    if (out_free) begin
                        r_out_data  <= {2'b00, r_p_space, r_p_level, r_p_event,
                                        sd_byte, r_p_send, rd_byte, r_p_acc};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
